/* sv/wjs_pkg.sv */
// wjs_pkg: shared types and constants of the wave join synchronizer.
// No dependencies; imported by the interfaces, wjs_front, wjs_back and the core.
package wjs_pkg;

  localparam int PORT_W   = 3;   // source_port / result_port width
  localparam int IN_HND_W = 32;  // packet_handle / result_handle width
  localparam int ACT_W    = 4;   // active_ports register width
  localparam int KIND_W   = 2;
  localparam int MAX_WAVE = 8;   // most members a wave may carry

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

  localparam logic [KIND_W-1:0] KIND_WAVE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INACTIVE = 2'd2;

  // command handed from front to back through the command queue
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [ACT_W-1:0]  n;     // wave size, used by wave commands
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

/* sv/wjs_ifs.sv */
// Handshake channel interfaces of the wave join synchronizer.
// Depends on wjs_pkg for field widths.
interface wjs_in_if;
  import wjs_pkg::*;
  logic                valid;
  logic                ready;
  logic [PORT_W-1:0]   source_port;
  logic [IN_HND_W-1:0] packet_handle;
  modport source (output valid, source_port, packet_handle, input ready);
  modport sink   (input valid, source_port, packet_handle, output ready);
endinterface

interface wjs_out_if;
  import wjs_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [PORT_W-1:0]   result_port;
  logic [IN_HND_W-1:0] result_handle;
  logic                wave_last;
  modport source (output valid, result_kind, result_port, result_handle, wave_last,
                  input ready);
  modport sink   (input valid, result_kind, result_port, result_handle, wave_last,
                  output ready);
endinterface

interface wjs_cfg_if;
  import wjs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/wjs_front.sv */
// wjs_front: accepts packets, classifies them (drop or enqueue), keeps the
// per-port counts and tails, and decides when a wave is complete.
// Depends on wjs_pkg and wjs_ifs.
module wjs_front #(
  parameter int NUM_PORTS   = 8,
  parameter int FIFO_DEPTH  = 16,
  parameter int HANDLE_BITS = 32,
  localparam int NPU = (NUM_PORTS < wjs_pkg::MAX_WAVE) ? NUM_PORTS : wjs_pkg::MAX_WAVE,
  localparam int AW  = $clog2(NPU * FIFO_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  wjs_in_if.sink                 in_ch,
  wjs_cfg_if.sink                cfg_ch,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output wjs_pkg::cmd_t          cmd,
  output logic [HANDLE_BITS-1:0] cmd_handle,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [HANDLE_BITS-1:0] mem_wdata,
  input  logic                   wave_done
);
  import wjs_pkg::*;

  localparam int IW = (NPU > 1) ? $clog2(NPU) : 1;
  localparam int SW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [ACT_W-1:0] act_r;
  logic [CW-1:0]    cnt_r   [NPU];
  logic [CW-1:0]    cnt_inc [NPU];
  logic [CW-1:0]    cnt_nxt [NPU];
  logic [SW-1:0]    tail_r  [NPU];
  logic [SW-1:0]    tail_nxt[NPU];
  logic             pend_r, pend_nxt;

  logic [ACT_W-1:0]       n_eff;
  logic [IW-1:0]          idx;
  logic [HANDLE_BITS-1:0] hnd;
  logic                   accept, inactive, full, enq, all_held, fire;

  // clamp the active count to 1 .. min(NUM_PORTS, 8)
  always_comb begin
    if (act_r == '0) begin
      n_eff = ACT_W'(1);
    end else if (act_r > ACT_W'(NPU)) begin
      n_eff = ACT_W'(NPU);
    end else begin
      n_eff = act_r;
    end
  end

  assign hnd      = HANDLE_BITS'(in_ch.packet_handle);
  assign idx      = in_ch.source_port[IW-1:0];
  assign in_ch.ready = !pend_r && cmd_ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign inactive = ACT_W'(in_ch.source_port) >= n_eff;
  assign full     = !inactive && (cnt_r[idx] == CW'(FIFO_DEPTH));
  assign enq      = accept && !inactive && !full;

  always_comb begin
    all_held = 1'b1;
    for (int p = 0; p < NPU; p++) begin
      cnt_inc[p]  = cnt_r[p] + CW'(enq && (idx == IW'(p)));
      tail_nxt[p] = tail_r[p];
      if ((ACT_W'(p) < n_eff) && (cnt_inc[p] == '0)) begin
        all_held = 1'b0;
      end
    end
    fire = enq && all_held;
    for (int p = 0; p < NPU; p++) begin
      cnt_nxt[p] = cnt_inc[p] - CW'(fire && (ACT_W'(p) < n_eff));
    end
    if (enq) begin
      tail_nxt[idx] = (tail_r[idx] == SW'(FIFO_DEPTH - 1)) ? '0 : tail_r[idx] + SW'(1);
    end
  end

  // input is held off from wave issue until the back has read every head
  always_comb begin
    pend_nxt = pend_r;
    if (fire) begin
      pend_nxt = 1'b1;
    end else if (wave_done) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd_valid  = accept && (inactive || full || fire);
    cmd.kind   = inactive ? KIND_INACTIVE : (full ? KIND_FULL : KIND_WAVE);
    cmd.port   = in_ch.source_port;
    cmd.n      = n_eff;
    cmd_handle = hnd;
  end

  assign mem_we    = enq;
  assign mem_waddr = AW'(idx) * AW'(FIFO_DEPTH) + AW'(tail_r[idx]);
  assign mem_wdata = hnd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= ACT_RESET;
      pend_r <= 1'b0;
      for (int p = 0; p < NPU; p++) begin
        cnt_r[p]  <= '0;
        tail_r[p] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        act_r <= cfg_ch.data;
      end
      pend_r <= pend_nxt;
      for (int p = 0; p < NPU; p++) begin
        cnt_r[p]  <= cnt_nxt[p];
        tail_r[p] <= tail_nxt[p];
      end
    end
  end

endmodule

/* sv/wjs_cmdq.sv */
// wjs_cmdq: short command FIFO between the front and the back.
// Depends on nothing; payload is a flat vector.
module wjs_cmdq #(
  parameter int DW    = 41,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] slot_r[DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic          do_push, do_pop;

  assign push_ready = num_r != NW'(DEPTH);
  assign pop_valid  = num_r != '0;
  assign pop_data   = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    num_nxt = num_r + NW'(do_push) - NW'(do_pop);
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      num_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      num_r <= num_nxt;
    end
  end

endmodule

/* sv/wjs_back.sv */
// wjs_back: executes commands from the queue. Holds the handle store and the
// per-port heads, reads one wave member per cycle while the output is not
// stalled, and drives the result port. Depends on wjs_pkg and wjs_ifs.
module wjs_back #(
  parameter int NUM_PORTS   = 8,
  parameter int FIFO_DEPTH  = 16,
  parameter int HANDLE_BITS = 32,
  localparam int NPU = (NUM_PORTS < wjs_pkg::MAX_WAVE) ? NUM_PORTS : wjs_pkg::MAX_WAVE,
  localparam int AW  = $clog2(NPU * FIFO_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  wjs_pkg::cmd_t          cmd,
  input  logic [HANDLE_BITS-1:0] cmd_handle,
  input  logic                   mem_we,
  input  logic [AW-1:0]          mem_waddr,
  input  logic [HANDLE_BITS-1:0] mem_wdata,
  output logic                   wave_done,
  wjs_out_if.source              out_ch
);
  import wjs_pkg::*;

  localparam int IW = (NPU > 1) ? $clog2(NPU) : 1;
  localparam int SW = $clog2(FIFO_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAVE = 1'b1;

  logic [HANDLE_BITS-1:0] store[NPU * FIFO_DEPTH];
  logic [HANDLE_BITS-1:0] mem_q_r;

  logic             st_r, st_nxt;
  logic [IW-1:0]    wp_r, wp_nxt;
  logic [ACT_W-1:0] wn_r, wn_nxt;
  logic [SW-1:0]    head_r[NPU];
  logic [SW-1:0]    head_nxt[NPU];

  // output register
  logic                   rd_v_r, rd_v_nxt;
  logic [KIND_W-1:0]      rd_kind_r, rd_kind_nxt;
  logic [PORT_W-1:0]      rd_port_r, rd_port_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic [HANDLE_BITS-1:0] rd_h_r, rd_h_nxt;

  logic          adv, rd_en, last_mem;
  logic [AW-1:0] raddr;

  assign adv      = !rd_v_r || out_ch.ready;
  assign raddr    = AW'(wp_r) * AW'(FIFO_DEPTH) + AW'(head_r[wp_r]);
  assign last_mem = (ACT_W'(wp_r) + ACT_W'(1)) == wn_r;

  always_comb begin
    st_nxt      = st_r;
    wp_nxt      = wp_r;
    wn_nxt      = wn_r;
    head_nxt    = head_r;
    rd_v_nxt    = rd_v_r && !out_ch.ready;
    rd_kind_nxt = rd_kind_r;
    rd_port_nxt = rd_port_r;
    rd_last_nxt = rd_last_r;
    rd_h_nxt    = rd_h_r;
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    wave_done   = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && adv) begin
          cmd_pop = 1'b1;
          if (cmd.kind == KIND_WAVE) begin
            st_nxt = ST_WAVE;
            wp_nxt = '0;
            wn_nxt = cmd.n;
          end else begin
            rd_v_nxt    = 1'b1;
            rd_kind_nxt = cmd.kind;
            rd_port_nxt = cmd.port;
            rd_last_nxt = 1'b1;
            rd_h_nxt    = cmd_handle;
          end
        end
      end
      ST_WAVE: begin
        if (adv) begin
          rd_en        = 1'b1;
          rd_v_nxt     = 1'b1;
          rd_kind_nxt  = KIND_WAVE;
          rd_port_nxt  = PORT_W'(wp_r);
          rd_last_nxt  = last_mem;
          head_nxt[wp_r] = (head_r[wp_r] == SW'(FIFO_DEPTH - 1)) ? '0
                                                                 : head_r[wp_r] + SW'(1);
          if (last_mem) begin
            st_nxt    = ST_IDLE;
            wave_done = 1'b1;
          end else begin
            wp_nxt = wp_r + IW'(1);
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q_r <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    rd_kind_r <= rd_kind_nxt;
    rd_port_r <= rd_port_nxt;
    rd_last_r <= rd_last_nxt;
    rd_h_r    <= rd_h_nxt;
    wn_r      <= wn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wp_r   <= '0;
      rd_v_r <= 1'b0;
      for (int p = 0; p < NPU; p++) begin
        head_r[p] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      wp_r   <= wp_nxt;
      rd_v_r <= rd_v_nxt;
      head_r <= head_nxt;
    end
  end

  assign out_ch.valid         = rd_v_r;
  assign out_ch.result_kind   = rd_kind_r;
  assign out_ch.result_port   = rd_port_r;
  assign out_ch.result_handle = (rd_kind_r == KIND_WAVE) ? IN_HND_W'(mem_q_r)
                                                         : IN_HND_W'(rd_h_r);
  assign out_ch.wave_last     = rd_last_r;

endmodule

/* sv/wave_join_synchronizer_core.sv */
// wave_join_synchronizer_core: top level of the multi-input barrier join.
// Depends on wjs_pkg, wjs_ifs, wjs_front, wjs_cmdq and wjs_back.
//
// Packets arrive one per cycle tagged with their source port. Ports below
// the active count (active_ports, clamped to 1 .. min(NUM_PORTS, 8)) each
// own a FIFO of FIFO_DEPTH handles; a packet for an inactive port or a full
// FIFO is reported at once as a single drop item with wave_last set. When a
// packet leaves every active port holding at least one handle, a wave goes
// out: the head of each active port in port order, last member marked.
// Drops and non-completing packets are taken one per cycle while the command
// queue has room. A completing packet holds off further input until the back
// end has read all n heads from the shared handle memory, one read per cycle
// while the output is not stalled. A four-entry command queue lets the front
// keep accepting while results wait on a stalled output. No clearing pass is
// needed after reset. Write active_ports only while idle.
module wave_join_synchronizer_core #(
  parameter int NUM_PORTS   = 8,
  parameter int FIFO_DEPTH  = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  wjs_in_if.sink     in_ch,
  wjs_cfg_if.sink    cfg_ch,
  wjs_out_if.source  out_ch
);
  import wjs_pkg::*;

  localparam int NPU = (NUM_PORTS < MAX_WAVE) ? NUM_PORTS : MAX_WAVE;
  localparam int AW  = $clog2(NPU * FIFO_DEPTH);
  localparam int DW  = CMD_W + HANDLE_BITS;

  logic                   f_cmd_valid, f_cmd_ready;
  cmd_t                   f_cmd;
  logic [HANDLE_BITS-1:0] f_cmd_handle;
  logic                   q_valid, q_pop;
  logic [DW-1:0]          q_data;
  cmd_t                   b_cmd;
  logic [HANDLE_BITS-1:0] b_cmd_handle;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic                   wave_done;

  wjs_front #(
    .NUM_PORTS  (NUM_PORTS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd_valid (f_cmd_valid),
    .cmd_ready (f_cmd_ready),
    .cmd       (f_cmd),
    .cmd_handle(f_cmd_handle),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .wave_done (wave_done)
  );

  wjs_cmdq #(
    .DW   (DW),
    .DEPTH(4)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_cmd_valid),
    .push_ready(f_cmd_ready),
    .push_data ({f_cmd, f_cmd_handle}),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_data  (q_data)
  );

  assign b_cmd        = cmd_t'(q_data[DW-1 -: CMD_W]);
  assign b_cmd_handle = q_data[HANDLE_BITS-1:0];

  wjs_back #(
    .NUM_PORTS  (NUM_PORTS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (b_cmd),
    .cmd_handle(b_cmd_handle),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .wave_done (wave_done),
    .out_ch    (out_ch)
  );

endmodule
